// File: design/qrs_pkg.sv
// Package for the quadratic root solver: widths, root kinds, queue item and
// pipeline side-band types, and the output clipping function. No dependencies.
package qrs_pkg;

   localparam int COEF_W    = 16;
   localparam int COEF_FRAC = 8;
   localparam int THR_W     = 16;
   localparam int ROOT_W    = 32;
   localparam int ROOT_FRAC = 16;
   localparam int PROD_W    = 2 * COEF_W;
   localparam int DISC_W    = PROD_W + 2;
   localparam int DMAG_W    = DISC_W - 1;
   localparam int DEN_W     = COEF_W + 1;
   localparam int NB_W      = COEF_W + ROOT_FRAC - COEF_FRAC + 1;
   localparam int RAD_W     = 50;
   localparam int SQ_STEPS  = RAD_W / 2;
   localparam int SQ_ROOT_W = SQ_STEPS;
   localparam int SQ_REM_W  = SQ_ROOT_W + 3;
   localparam int NUM_W     = NB_W + 2;
   localparam int MAG_W     = NUM_W - 1;
   localparam int DIV_N_W   = MAG_W + COEF_FRAC;
   localparam int DIV_STEPS = DIV_N_W;
   localparam int QV_W      = DIV_N_W + 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   typedef enum logic [1:0] {
      KIND_DOUBLE  = 2'd0,
      KIND_REAL    = 2'd1,
      KIND_COMPLEX = 2'd2,
      KIND_A_ZERO  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type                 kind;
      logic                     neg_a;
      logic [DEN_W-1:0]         den;
      logic signed [NB_W-1:0]   neg_b;
      logic [DMAG_W-1:0]        dmag;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic                     valid;
      kind_type                 kind;
      logic                     neg_a;
      logic [DEN_W-1:0]         den;
      logic signed [NB_W-1:0]   neg_b;
   } sq_meta_type;

   typedef struct packed {
      logic     valid;
      kind_type kind;
      logic     neg1;
      logic     neg2;
      logic     neg3;
   } div_meta_type;

   // Returns the saturation flag above the clipped root value.
   function automatic logic [ROOT_W:0] clip_root(input logic signed [QV_W-1:0] v);
      logic in_range;
      in_range = (&v[QV_W-1:ROOT_W-1]) | ~(|v[QV_W-1:ROOT_W-1]);
      if (in_range) begin
         clip_root = {1'b0, v[ROOT_W-1:0]};
      end else if (v[QV_W-1]) begin
         clip_root = {1'b1, 1'b1, {(ROOT_W-1){1'b0}}};
      end else begin
         clip_root = {1'b1, 1'b0, {(ROOT_W-1){1'b1}}};
      end
   endfunction

endpackage

// File: design/quadratic_root_solver_unit.sv
// Quadratic root solver: one request per cycle sustained while neither side stalls,
// results in order. An accepted request passes through the front stage, the queue,
// 25 square root stages, one set-up stage, 34 divider stages and the result
// register. Reset is synchronous, active high; it empties the pipeline and the
// queue and clears the threshold to zero.
module quadratic_root_solver_unit import qrs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [COEF_W-1:0] req_coef_a,
   input  logic signed [COEF_W-1:0] req_coef_b,
   input  logic signed [COEF_W-1:0] req_coef_c,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_root_kind,
   output logic signed [ROOT_W-1:0] rsp_first_real,
   output logic signed [ROOT_W-1:0] rsp_first_imag,
   output logic signed [ROOT_W-1:0] rsp_second_real,
   output logic signed [ROOT_W-1:0] rsp_second_imag,
   output logic                     rsp_saturated,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [THR_W-1:0]         csr_data
);

   logic [THR_W-1:0] threshold_ff;
   queue_status_type queue_status;
   item_type         push_item, pop_item;
   logic             push, pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         threshold_ff <= csr_data;
      end
   end

   qrs_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_coef_a   (req_coef_a),
      .req_coef_b   (req_coef_b),
      .req_coef_c   (req_coef_c),
      .threshold    (threshold_ff),
      .queue_status (queue_status),
      .push         (push),
      .push_item    (push_item)
   );

   qrs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .status    (queue_status)
   );

   qrs_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_status    (queue_status),
      .pop_item        (pop_item),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_root_kind   (rsp_root_kind),
      .rsp_first_real  (rsp_first_real),
      .rsp_first_imag  (rsp_first_imag),
      .rsp_second_real (rsp_second_real),
      .rsp_second_imag (rsp_second_imag),
      .rsp_saturated   (rsp_saturated)
   );

endmodule

// File: design/qrs_front.sv
// Front part of the quadratic root solver: accepts a request, forms the
// discriminant and classifies it, then pushes the item into the queue. Uses qrs_pkg.
module qrs_front import qrs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [COEF_W-1:0] req_coef_a,
   input  logic signed [COEF_W-1:0] req_coef_b,
   input  logic signed [COEF_W-1:0] req_coef_c,
   input  logic [THR_W-1:0]         threshold,
   input  queue_status_type         queue_status,
   output logic                     push,
   output item_type                 push_item
);

   logic                     f1_valid_ff;
   logic signed [COEF_W-1:0] a_ff, b_ff;
   logic signed [PROD_W-1:0] bb_ff, ac_ff;
   logic signed [DISC_W-1:0] disc;
   logic signed [DEN_W-1:0]  two_a;
   logic                     advance;

   assign req_stall = f1_valid_ff & queue_status.full;
   assign advance   = ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else if (advance) begin
         f1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_valid) begin
         a_ff  <= req_coef_a;
         b_ff  <= req_coef_b;
         bb_ff <= req_coef_b * req_coef_b;
         ac_ff <= req_coef_a * req_coef_c;
      end
   end

   always_comb begin
      disc  = {{2{bb_ff[PROD_W-1]}}, bb_ff} - {ac_ff, 2'b00};
      two_a = {a_ff, 1'b0};
      push_item.dmag  = disc[DISC_W-1] ? DMAG_W'(-disc) : disc[DMAG_W-1:0];
      push_item.neg_a = a_ff[COEF_W-1];
      push_item.den   = two_a[DEN_W-1] ? DEN_W'(-two_a) : DEN_W'(two_a);
      push_item.neg_b = -($signed({b_ff[COEF_W-1], b_ff}) <<< (ROOT_FRAC - COEF_FRAC));
      if (a_ff == '0) begin
         push_item.kind = KIND_A_ZERO;
      end else if (push_item.dmag <= DMAG_W'(threshold)) begin
         push_item.kind = KIND_DOUBLE;
      end else if (!disc[DISC_W-1]) begin
         push_item.kind = KIND_REAL;
      end else begin
         push_item.kind = KIND_COMPLEX;
      end
   end

   assign push = f1_valid_ff;

endmodule

// File: design/qrs_queue.sv
// Short request queue between the front and back parts of the root solver.
// Uses qrs_pkg for the item type and depth.
module qrs_queue import qrs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  item_type         push_item,
   input  logic             pop,
   output item_type         pop_item,
   output queue_status_type status
);

   item_type              mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ff, rd_ff;
   logic [QUEUE_AW:0]     count_ff;
   logic                  do_push, do_pop;

   assign status.full  = count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH);
   assign status.empty = count_ff == '0;
   assign do_push      = push & ~status.full;
   assign do_pop       = pop & ~status.empty;
   assign pop_item     = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// File: design/qrs_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Uses qrs_pkg for its widths.
module qrs_sqrt import qrs_pkg::*; (
   input  logic                 clock,
   input  logic                 enable,
   input  logic [RAD_W-1:0]     rad_value,
   output logic [SQ_ROOT_W-1:0] root_value
);

   logic [SQ_REM_W-1:0]  rem_ff  [SQ_STEPS];
   logic [SQ_ROOT_W-1:0] root_ff [SQ_STEPS];
   logic [RAD_W-1:0]     rad_ff  [SQ_STEPS];
   logic [SQ_REM_W-1:0]  rem_w   [SQ_STEPS+1];
   logic [SQ_ROOT_W-1:0] root_w  [SQ_STEPS+1];
   logic [RAD_W-1:0]     rad_w   [SQ_STEPS+1];

   assign rem_w[0]  = '0;
   assign root_w[0] = '0;
   assign rad_w[0]  = rad_value;

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
      logic [SQ_REM_W-1:0] cand, trial, rem_in;
      logic                ge;
      assign cand   = {rem_w[k][SQ_REM_W-3:0], rad_w[k][RAD_W-1:RAD_W-2]};
      assign trial  = {1'b0, root_w[k], 2'b01};
      assign ge     = cand >= trial;
      assign rem_in = ge ? cand - trial : cand;
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= {root_w[k][SQ_ROOT_W-2:0], ge};
            rad_ff[k]  <= {rad_w[k][RAD_W-3:0], 2'b00};
         end
      end
      assign rem_w[k+1]  = rem_ff[k];
      assign root_w[k+1] = root_ff[k];
      assign rad_w[k+1]  = rad_ff[k];
   end

   assign root_value = root_w[SQ_STEPS];

endmodule

// File: design/qrs_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
// Uses qrs_pkg for its widths.
module qrs_divider import qrs_pkg::*; (
   input  logic               clock,
   input  logic               enable,
   input  logic [DIV_N_W-1:0] num_value,
   input  logic [DEN_W-1:0]   den_value,
   output logic [DIV_N_W-1:0] quot_value,
   output logic [DEN_W-1:0]   rem_value
);

   logic [DEN_W-1:0]   rem_ff  [DIV_STEPS];
   logic [DIV_N_W-1:0] num_ff  [DIV_STEPS];
   logic [DIV_N_W-1:0] quot_ff [DIV_STEPS];
   logic [DEN_W-1:0]   den_ff  [DIV_STEPS];
   logic [DEN_W-1:0]   rem_w   [DIV_STEPS+1];
   logic [DIV_N_W-1:0] num_w   [DIV_STEPS+1];
   logic [DIV_N_W-1:0] quot_w  [DIV_STEPS+1];
   logic [DEN_W-1:0]   den_w   [DIV_STEPS+1];

   assign rem_w[0]  = '0;
   assign num_w[0]  = num_value;
   assign quot_w[0] = '0;
   assign den_w[0]  = den_value;

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [DEN_W:0] cand, diff;
      logic           ge;
      assign cand = {rem_w[k], num_w[k][DIV_N_W-1]};
      assign ge   = cand >= {1'b0, den_w[k]};
      assign diff = cand - {1'b0, den_w[k]};
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k]  <= ge ? diff[DEN_W-1:0] : cand[DEN_W-1:0];
            num_ff[k]  <= {num_w[k][DIV_N_W-2:0], 1'b0};
            quot_ff[k] <= {quot_w[k][DIV_N_W-2:0], ge};
            den_ff[k]  <= den_w[k];
         end
      end
      assign rem_w[k+1]  = rem_ff[k];
      assign num_w[k+1]  = num_ff[k];
      assign quot_w[k+1] = quot_ff[k];
      assign den_w[k+1]  = den_ff[k];
   end

   assign quot_value = quot_w[DIV_STEPS];
   assign rem_value  = rem_w[DIV_STEPS];

endmodule

// File: design/qrs_back.sv
// Back part of the root solver: square root, numerator set-up, three dividers,
// rounding, clipping and the result register. Uses qrs_pkg, qrs_sqrt, qrs_divider.
module qrs_back import qrs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  queue_status_type         queue_status,
   input  item_type                 pop_item,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_root_kind,
   output logic signed [ROOT_W-1:0] rsp_first_real,
   output logic signed [ROOT_W-1:0] rsp_first_imag,
   output logic signed [ROOT_W-1:0] rsp_second_real,
   output logic signed [ROOT_W-1:0] rsp_second_imag,
   output logic                     rsp_saturated
);

   logic                 advance;
   sq_meta_type          sq_meta_ff [SQ_STEPS];
   sq_meta_type          sq_meta_w  [SQ_STEPS+1];
   logic [SQ_ROOT_W-1:0] root;
   div_meta_type         pr_meta_ff;
   logic [DEN_W-1:0]     pr_den_ff;
   logic [DIV_N_W-1:0]   pr_n1_ff, pr_n2_ff, pr_n3_ff;
   div_meta_type         dv_meta_ff [DIV_STEPS];
   div_meta_type         dv_meta_w  [DIV_STEPS+1];
   logic [DIV_N_W-1:0]   q1, q2, q3;
   logic [DEN_W-1:0]     r1, r2, r3, dv_den;
   logic signed [NUM_W-1:0] nb_ext, s_ext, num1, num2;
   logic [MAG_W-1:0]     mag1, mag2;
   logic signed [QV_W-1:0] sv1, sv2, sv3;
   logic [ROOT_W:0]      c1, c2, c3, c4;
   logic                 rsp_valid_ff, rsp_sat_ff;
   kind_type             rsp_kind_ff;
   logic [ROOT_W-1:0]    fr_ff, fi_ff, sr_ff, si_ff;

   assign advance = ~rsp_valid_ff | ~rsp_stall;
   assign pop     = advance & ~queue_status.empty;

   assign sq_meta_w[0] = '{valid: ~queue_status.empty, kind: pop_item.kind,
                           neg_a: pop_item.neg_a, den: pop_item.den,
                           neg_b: pop_item.neg_b};

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq_meta
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_meta_ff[k] <= '0;
         end else if (advance) begin
            sq_meta_ff[k] <= sq_meta_w[k];
         end
      end
      assign sq_meta_w[k+1] = sq_meta_ff[k];
   end

   qrs_sqrt u_sqrt (
      .clock      (clock),
      .enable     (advance),
      .rad_value  ({1'b0, pop_item.dmag, {(2*(ROOT_FRAC-COEF_FRAC)){1'b0}}}),
      .root_value (root)
   );

   always_comb begin
      nb_ext = NUM_W'(sq_meta_w[SQ_STEPS].neg_b);
      s_ext  = $signed({2'b00, root});
      if (sq_meta_w[SQ_STEPS].kind == KIND_REAL) begin
         num1 = nb_ext + s_ext;
         num2 = nb_ext - s_ext;
      end else begin
         num1 = nb_ext;
         num2 = nb_ext;
      end
      mag1 = num1[NUM_W-1] ? MAG_W'(-num1) : num1[MAG_W-1:0];
      mag2 = num2[NUM_W-1] ? MAG_W'(-num2) : num2[MAG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_meta_ff <= '0;
      end else if (advance) begin
         pr_meta_ff <= '{valid: sq_meta_w[SQ_STEPS].valid,
                         kind:  sq_meta_w[SQ_STEPS].kind,
                         neg1:  num1[NUM_W-1] ^ sq_meta_w[SQ_STEPS].neg_a,
                         neg2:  num2[NUM_W-1] ^ sq_meta_w[SQ_STEPS].neg_a,
                         neg3:  sq_meta_w[SQ_STEPS].neg_a};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pr_den_ff <= sq_meta_w[SQ_STEPS].den;
         pr_n1_ff  <= {mag1, {COEF_FRAC{1'b0}}};
         pr_n2_ff  <= {mag2, {COEF_FRAC{1'b0}}};
         pr_n3_ff  <= {{(MAG_W-SQ_ROOT_W){1'b0}}, root, {COEF_FRAC{1'b0}}};
      end
   end

   assign dv_meta_w[0] = pr_meta_ff;

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_dv_meta
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_meta_ff[k] <= '0;
         end else if (advance) begin
            dv_meta_ff[k] <= dv_meta_w[k];
         end
      end
      assign dv_meta_w[k+1] = dv_meta_ff[k];
   end

   qrs_divider u_div1 (.clock(clock), .enable(advance), .num_value(pr_n1_ff),
                       .den_value(pr_den_ff), .quot_value(q1), .rem_value(r1));
   qrs_divider u_div2 (.clock(clock), .enable(advance), .num_value(pr_n2_ff),
                       .den_value(pr_den_ff), .quot_value(q2), .rem_value(r2));
   qrs_divider u_div3 (.clock(clock), .enable(advance), .num_value(pr_n3_ff),
                       .den_value(pr_den_ff), .quot_value(q3), .rem_value(r3));

   // The divisor is carried alongside the quotient for the rounding compare.
   logic [DEN_W-1:0] den_line_ff [DIV_STEPS];
   logic [DEN_W-1:0] den_line_w  [DIV_STEPS+1];
   assign den_line_w[0] = pr_den_ff;
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_den
      always_ff @(posedge clock) begin
         if (advance) begin
            den_line_ff[k] <= den_line_w[k];
         end
      end
      assign den_line_w[k+1] = den_line_ff[k];
   end
   assign dv_den = den_line_w[DIV_STEPS];

   function automatic logic signed [QV_W-1:0] finish(input logic [DIV_N_W-1:0] q,
                                                     input logic [DEN_W-1:0] r,
                                                     input logic [DEN_W-1:0] d,
                                                     input logic neg);
      logic [QV_W-1:0] mag;
      mag = {2'b00, q} + QV_W'({r, 1'b0} >= {1'b0, d});
      finish = neg ? -$signed(mag) : $signed(mag);
   endfunction

   always_comb begin
      sv1 = finish(q1, r1, dv_den, dv_meta_w[DIV_STEPS].neg1);
      sv2 = finish(q2, r2, dv_den, dv_meta_w[DIV_STEPS].neg2);
      sv3 = finish(q3, r3, dv_den, dv_meta_w[DIV_STEPS].neg3);
      c1  = clip_root(sv1);
      c2  = clip_root(sv2);
      c3  = clip_root(sv3);
      c4  = clip_root(-sv3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_meta_w[DIV_STEPS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_kind_ff <= dv_meta_w[DIV_STEPS].kind;
         case (dv_meta_w[DIV_STEPS].kind)
            KIND_A_ZERO: begin
               fr_ff <= '0; fi_ff <= '0; sr_ff <= '0; si_ff <= '0;
               rsp_sat_ff <= 1'b0;
            end
            KIND_REAL: begin
               fr_ff <= c1[ROOT_W-1:0]; sr_ff <= c2[ROOT_W-1:0];
               fi_ff <= '0; si_ff <= '0;
               rsp_sat_ff <= c1[ROOT_W] | c2[ROOT_W];
            end
            KIND_COMPLEX: begin
               fr_ff <= c1[ROOT_W-1:0]; sr_ff <= c1[ROOT_W-1:0];
               fi_ff <= c3[ROOT_W-1:0]; si_ff <= c4[ROOT_W-1:0];
               rsp_sat_ff <= c1[ROOT_W] | c3[ROOT_W] | c4[ROOT_W];
            end
            default: begin
               fr_ff <= c1[ROOT_W-1:0]; sr_ff <= c1[ROOT_W-1:0];
               fi_ff <= '0; si_ff <= '0;
               rsp_sat_ff <= c1[ROOT_W];
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_root_kind   = rsp_kind_ff;
   assign rsp_first_real  = fr_ff;
   assign rsp_first_imag  = fi_ff;
   assign rsp_second_real = sr_ff;
   assign rsp_second_imag = si_ff;
   assign rsp_saturated   = rsp_sat_ff;

endmodule

// File: design/qrs_checker.sv
// Port-level checker for the quadratic root solver and its bind statement.
// Uses qrs_pkg for root kinds and widths.
module qrs_checker import qrs_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [1:0]               rsp_root_kind,
   input logic signed [ROOT_W-1:0] rsp_first_real,
   input logic signed [ROOT_W-1:0] rsp_first_imag,
   input logic signed [ROOT_W-1:0] rsp_second_real,
   input logic signed [ROOT_W-1:0] rsp_second_imag,
   input logic                     rsp_saturated
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_first_real)
         && $stable(rsp_second_imag))
      else $error("Stalled response changed.");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Response valid after reset.");

   a_azero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_root_kind == KIND_A_ZERO |-> rsp_first_real == 0
         && rsp_first_imag == 0 && rsp_second_real == 0 && rsp_second_imag == 0
         && !rsp_saturated)
      else $error("Zero leading coefficient gave non-zero roots.");

   a_same_real: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_root_kind == KIND_DOUBLE || rsp_root_kind == KIND_COMPLEX)
         |-> rsp_first_real == rsp_second_real)
      else $error("Real parts differ.");

   a_conj: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_root_kind == KIND_COMPLEX && !rsp_saturated
         |-> rsp_second_imag == -rsp_first_imag)
      else $error("Complex pair is not conjugate.");

endmodule

bind quadratic_root_solver_unit qrs_checker u_checker (.*);

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for quadratic_root_solver_unit: random and directed requests are
// predicted by a scoreboard class and compared field by field. Depends on qrs_pkg.
module testbench;
   import qrs_pkg::*;

   typedef struct {
      kind_type   kind;
      logic [31:0] r1, i1, r2, i2;
      logic       sat;
   } roots_type;

   class root_scoreboard;
      logic [THR_W-1:0] threshold;
      roots_type        pending[$];
      int               mismatches;
      int               kind_count[4];

      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned res, bit_w;
         res = 0;
         bit_w = 64'd1 << 62;
         while (bit_w > v) bit_w = bit_w >> 2;
         while (bit_w != 0) begin
            if (v >= res + bit_w) begin
               v = v - (res + bit_w);
               res = (res >> 1) + bit_w;
            end else begin
               res = res >> 1;
            end
            bit_w = bit_w >> 2;
         end
         return res;
      endfunction

      function longint round_div(longint num, longint den);
         longint unsigned n, d, q, r;
         logic            neg;
         neg = (num < 0) != (den < 0);
         n = (num < 0) ? -num : num;
         d = (den < 0) ? -den : den;
         n = n << COEF_FRAC;
         q = n / d;
         r = n % d;
         if (r >= d - r) q++;
         return neg ? -longint'(q) : longint'(q);
      endfunction

      function logic [31:0] clip(longint v, ref logic sat);
         if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'h7fffffff;
         end
         if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'h80000000;
         end
         return v[31:0];
      endfunction

      function void note_request(logic signed [15:0] a, logic signed [15:0] b,
                                 logic signed [15:0] c);
         roots_type       e;
         longint          sa, sb, sc, disc, two_a, nb, x1, y1, x2, y2;
         longint unsigned dmag, s;
         logic            sat;
         sa = a; sb = b; sc = c;
         sat = 1'b0;
         if (sa == 0) begin
            e = '{KIND_A_ZERO, 0, 0, 0, 0, 1'b0};
         end else begin
            disc = sb * sb - 4 * sa * sc;
            dmag = (disc < 0) ? -disc : disc;
            two_a = 2 * sa;
            nb = -sb * 256;
            s = int_sqrt(dmag << 16);
            y1 = 0;
            y2 = 0;
            if (dmag <= threshold) begin
               e.kind = KIND_DOUBLE;
               x1 = round_div(nb, two_a);
               x2 = x1;
            end else if (disc > 0) begin
               e.kind = KIND_REAL;
               x1 = round_div(nb + longint'(s), two_a);
               x2 = round_div(nb - longint'(s), two_a);
            end else begin
               e.kind = KIND_COMPLEX;
               x1 = round_div(nb, two_a);
               x2 = x1;
               y1 = round_div(longint'(s), two_a);
               y2 = -y1;
            end
            e.r1 = clip(x1, sat);
            e.i1 = clip(y1, sat);
            e.r2 = clip(x2, sat);
            e.i2 = clip(y2, sat);
            e.sat = sat;
         end
         pending.push_back(e);
      endfunction

      function void check_result(roots_type got);
         roots_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Result arrived with nothing outstanding.");
            return;
         end
         e = pending.pop_front();
         kind_count[e.kind]++;
         if (got.kind !== e.kind || got.r1 !== e.r1 || got.i1 !== e.i1 ||
             got.r2 !== e.r2 || got.i2 !== e.i2 || got.sat !== e.sat) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Mismatch: expected %0d %h %h %h %h %b, got %0d %h %h %h %h %b",
                        e.kind, e.r1, e.i1, e.r2, e.i2, e.sat,
                        got.kind, got.r1, got.i1, got.r2, got.i2, got.sat);
         end
      endfunction
   endclass

   logic                     clock, reset;
   logic                     req_valid, req_stall;
   logic signed [COEF_W-1:0] req_coef_a, req_coef_b, req_coef_c;
   logic                     rsp_valid, rsp_stall;
   logic [1:0]               rsp_root_kind;
   logic signed [ROOT_W-1:0] rsp_first_real, rsp_first_imag;
   logic signed [ROOT_W-1:0] rsp_second_real, rsp_second_imag;
   logic                     rsp_saturated;
   logic                     csr_valid, csr_ready;
   logic [THR_W-1:0]         csr_data;

   root_scoreboard sb;
   int  cycles;
   int  requests_sent;
   bit  quiet;
   bit  hold_request;

   quadratic_root_solver_unit u_dut (.*);

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 600000) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      roots_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind = kind_type'(rsp_root_kind);
         got.r1 = rsp_first_real;
         got.i1 = rsp_first_imag;
         got.r2 = rsp_second_real;
         got.i2 = rsp_second_imag;
         got.sat = rsp_saturated;
         sb.check_result(got);
      end
   end

   // Receiver side: random stalls, and one long hold-off on request.
   initial begin
      int n;
      rsp_stall = 1'b1;
      @(negedge reset);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
         end
         n = quiet ? 0 : $urandom_range(0, 15);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   task automatic send_request(logic signed [15:0] a, logic signed [15:0] b,
                               logic signed [15:0] c);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_coef_a <= a;
      req_coef_b <= b;
      req_coef_c <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(a, b, c);
      requests_sent++;
   endtask

   task automatic write_threshold(logic [THR_W-1:0] v);
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (70) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sb.threshold = v;
   endtask

   task automatic random_request();
      logic signed [15:0] a, b, c;
      longint             q;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            a = $urandom;
            b = $urandom;
            c = $urandom;
         end
         4, 5: begin
            a = $urandom_range(0, 1024) - 512;
            b = $urandom_range(0, 1024) - 512;
            c = $urandom_range(0, 1024) - 512;
         end
         6, 7: begin
            a = $urandom_range(1, 2000);
            if ($urandom_range(0, 1)) a = -a;
            b = $urandom_range(0, 8000) - 4000;
            q = (longint'(b) * b) / (4 * longint'(a)) + longint'(int'($urandom_range(0, 4)))
                - 2;
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            c = q;
         end
         8: begin
            a = 0;
            b = $urandom;
            c = $urandom;
         end
         default: begin
            a = $urandom_range(0, 6) - 3;
            b = $urandom;
            c = $urandom;
         end
      endcase
      send_request(a, b, c);
   endtask

   initial begin
      logic [THR_W-1:0] thresholds[6];
      sb = new();
      sb.threshold = '0;
      cycles = 0;
      requests_sent = 0;
      quiet = 1'b0;
      hold_request = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_coef_a = '0;
      req_coef_b = '0;
      req_coef_c = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests: zero a, extreme coefficients, each root kind, clipping.
      send_request(16'sd0, 16'sd0, 16'sd0);
      send_request(16'sd0, 16'sh7fff, -16'sd32768);
      send_request(16'sd256, 16'sd0, 16'sd0);
      send_request(16'sd256, -16'sd512, 16'sd256);
      send_request(16'sd256, 16'sd0, -16'sd1024);
      send_request(16'sd256, 16'sd0, 16'sd1024);
      send_request(-16'sd256, 16'sd0, 16'sd1024);
      send_request(16'sd1, 16'sh7fff, 16'sd0);
      send_request(-16'sd1, 16'sh7fff, 16'sd0);
      send_request(16'sd1, -16'sd32768, 16'sd0);
      send_request(16'sd1, 16'sd0, -16'sd32768);
      send_request(16'sd1, 16'sd0, 16'sh7fff);
      send_request(16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_request(-16'sd32768, -16'sd32768, -16'sd32768);
      send_request(-16'sd32768, 16'sh7fff, 16'sh7fff);
      send_request(16'sh7fff, -16'sd32768, -16'sd32768);
      send_request(16'sd3, 16'sd5, 16'sd2);
      send_request(16'sd2, 16'sd3, -16'sd2);

      thresholds = '{16'd65535, 16'd1, 16'd0, 16'd1000, 16'd0, 16'd0};
      thresholds[3] = $urandom;
      foreach (thresholds[p]) begin
         write_threshold(thresholds[p]);
         if (p == 2) hold_request = 1'b1;
         quiet = (p == 4);
         send_request(16'sd256, -16'sd512, 16'sd256);
         repeat (290) random_request();
      end
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);

      $display("Requests sent: %0d over six threshold settings, including 0 and 65535.",
               requests_sent);
      $display("Results by kind: double %0d, real %0d, complex %0d, a zero %0d; mismatches %0d.",
               sb.kind_count[0], sb.kind_count[1], sb.kind_count[2], sb.kind_count[3],
               sb.mismatches);
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
